[rtl/bounded_ordered_list_engine_unit_defines.svh]
// Assertion macros for the list engine RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define BLOL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");
// Consequent must hold in the cycle after the antecedent.
`define BLOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");
`else
`define BLOL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BLOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/blol_pkg.sv]
package blol_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned LenW  = 6;

  typedef enum logic [2:0] {
    REQ_INS_FRONT,
    REQ_INS_POS,
    REQ_INS_END,
    REQ_DEL_FRONT,
    REQ_DEL_POS,
    REQ_DEL_END,
    REQ_DEL_VALUE,
    REQ_DISPLAY
  } req_type_e;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_OVERFLOW,
    STAT_RANGE,
    STAT_NOT_FOUND
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_DEL_CHK,
    ST_DEL_WR,
    ST_SRCH_CHK,
    ST_SRCH_CMP,
    ST_DISP_RD,
    ST_DISP_OUT,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    req_type_e                req_type;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  element;
    logic                     element_valid;
    logic [LenW-1:0]          length;
    logic                     last;
  } rsp_t;

endpackage

[rtl/bounded_ordered_list_engine_unit.sv]
// Channel   Direction  Handshake                  Payload
// request   in         req_valid_i / req_ready_o  req_i (blol_pkg::req_t)
// response  out        rsp_valid_o / rsp_ready_i  rsp_o (blol_pkg::rsp_t)
//
// A request transaction is taken only in an idle cycle and then holds the block until
// its last result is in the output register. A rejected request moves no entries; an
// insert at p moves n - p entries and a delete at p moves n - p - 1. A delete by value
// searches first, a display reads each entry; each step needs a registered read.
// Reset empties the list at once with no clearing pass. A stalled result waits in the
// output register; the sequencer pauses only when it must emit the next one.
`include "bounded_ordered_list_engine_unit_defines.svh"

module bounded_ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  blol_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output blol_pkg::rsp_t rsp_o
);
  import blol_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Memory port signals between the sequencer and the list storage.
  logic                    mem_we, mem_re;
  logic [IdxW-1:0]         mem_waddr, mem_raddr;
  logic signed [DataW-1:0] mem_wdata, mem_rdata;

  // The sequencer hands over one finished result at a time through this.
  logic slot_free, emit;
  rsp_t rsp_next;

  logic rsp_valid_q;
  rsp_t rsp_q;

  // The output register is free when empty or when its result is being taken.
  assign slot_free = !rsp_valid_q || rsp_ready_i;

  blol_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_i       (req_i),
    .req_ready_o (req_ready_o),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .rsp_o       (rsp_next),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  blol_mem #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: valid is control state and resets; the payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Once a request transaction is taken, the sequencer is busy in the next cycle.
  `BLOL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)
  // Only a display result carries an element, and it always reports success.
  `BLOL_ASSERT_SAME(a_element_ok, clk_i, rst_ni, rsp_valid_o && rsp_o.element_valid,
                    rsp_o.status == STAT_OK)
  // Every result without an element closes its request.
  `BLOL_ASSERT_SAME(a_plain_is_last, clk_i, rst_ni, rsp_valid_o && !rsp_o.element_valid,
                    rsp_o.last)

endmodule

[rtl/blol_mem.sv]
module blol_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic signed [blol_pkg::DataW-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic signed [blol_pkg::DataW-1:0] rdata_o
);
  import blol_pkg::*;

  logic signed [DataW-1:0] mem_q [Depth];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled output keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/blol_ctrl.sv]
module blol_ctrl #(
  parameter int unsigned Capacity = 32,
  parameter int unsigned IdxW     = $clog2(Capacity),
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  blol_pkg::req_t                    req_i,
  output logic                              req_ready_o,
  input  logic                              slot_free_i,
  output logic                              emit_o,
  output blol_pkg::rsp_t                    rsp_o,
  output logic                              mem_we_o,
  output logic [IdxW-1:0]                   mem_waddr_o,
  output logic signed [blol_pkg::DataW-1:0] mem_wdata_o,
  output logic                              mem_re_o,
  output logic [IdxW-1:0]                   mem_raddr_o,
  input  logic signed [blol_pkg::DataW-1:0] mem_rdata_i
);
  import blol_pkg::*;

  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  ctrl_state_e             state_q, state_d;
  status_e                 status_q, status_d;
  logic signed [DataW-1:0] value_q, value_d;
  logic [CntW-1:0]         pos_q, pos_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         count_q, count_d;

  logic [CntW-1:0] idx_inc, idx_dec;
  logic [CmpW-1:0] cnt_ext, pos_ext, acc_pos;
  logic            full, empty, is_ins, is_del, acc_bad;

  assign idx_inc = idx_q + CntW'(1);
  assign idx_dec = idx_q - CntW'(1);
  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(req_i.position);
  assign full    = (count_q == CntW'(Capacity));
  assign empty   = (count_q == '0);

  // Decode the target position of a new transaction and whether it is in range.
  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    acc_pos = '0;
    acc_bad = 1'b0;
    case (req_i.req_type)
      REQ_INS_FRONT, REQ_INS_POS, REQ_INS_END: begin
        is_ins  = 1'b1;
        acc_pos = (req_i.req_type == REQ_INS_FRONT) ? '0 :
                  (req_i.req_type == REQ_INS_POS) ? pos_ext : cnt_ext;
        acc_bad = (acc_pos > cnt_ext);
      end
      REQ_DEL_FRONT, REQ_DEL_POS, REQ_DEL_END: begin
        is_del  = 1'b1;
        acc_pos = (req_i.req_type == REQ_DEL_FRONT) ? '0 :
                  (req_i.req_type == REQ_DEL_POS) ? pos_ext : (cnt_ext - CmpW'(1));
        acc_bad = (acc_pos >= cnt_ext);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (is_ins) begin
            state_d = (full || acc_bad) ? ST_RESP : ST_INS_CHK;
          end else if (is_del) begin
            state_d = (empty || acc_bad) ? ST_RESP : ST_DEL_CHK;
          end else if (req_i.req_type == REQ_DEL_VALUE) begin
            state_d = empty ? ST_RESP : ST_SRCH_CHK;
          end else begin
            state_d = empty ? ST_RESP : ST_DISP_RD;
          end
        end
      end
      ST_INS_CHK:  state_d = (idx_q > pos_q) ? ST_INS_WR : ST_RESP;
      ST_INS_WR:   state_d = ST_INS_CHK;
      ST_DEL_CHK:  state_d = (idx_inc < count_q) ? ST_DEL_WR : ST_RESP;
      ST_DEL_WR:   state_d = ST_DEL_CHK;
      ST_SRCH_CHK: state_d = (idx_q < count_q) ? ST_SRCH_CMP : ST_RESP;
      ST_SRCH_CMP: state_d = (mem_rdata_i == value_q) ? ST_DEL_CHK : ST_SRCH_CHK;
      ST_DISP_RD:  state_d = ST_DISP_OUT;
      ST_DISP_OUT: begin
        if (slot_free_i) begin
          state_d = (idx_inc == count_q) ? ST_IDLE : ST_DISP_RD;
        end
      end
      ST_RESP: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    status_d    = status_q;
    value_d     = value_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    count_d     = count_q;
    req_ready_o = (state_q == ST_IDLE);
    emit_o      = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IdxW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[IdxW-1:0];
    rsp_o.status        = status_q;
    rsp_o.element       = '0;
    rsp_o.element_valid = 1'b0;
    rsp_o.length        = LenW'(count_q);
    rsp_o.last          = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          value_d = req_i.value;
          idx_d   = '0;
          pos_d   = CntW'(acc_pos);
          if (is_ins) begin
            status_d = full ? STAT_OVERFLOW : (acc_bad ? STAT_RANGE : STAT_OK);
            idx_d    = count_q;
          end else if (is_del) begin
            status_d = empty ? STAT_EMPTY : (acc_bad ? STAT_RANGE : STAT_OK);
            idx_d    = CntW'(acc_pos);
          end else if (req_i.req_type == REQ_DEL_VALUE) begin
            status_d = empty ? STAT_EMPTY : STAT_NOT_FOUND;
          end else begin
            status_d = empty ? STAT_EMPTY : STAT_OK;
          end
        end
      end
      ST_INS_CHK: begin
        if (idx_q > pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec[IdxW-1:0];
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = value_q;
          count_d     = count_q + CntW'(1);
        end
      end
      ST_INS_WR: begin
        mem_we_o = 1'b1;
        idx_d    = idx_dec;
      end
      ST_DEL_CHK: begin
        if (idx_inc < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_inc[IdxW-1:0];
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      ST_DEL_WR: begin
        mem_we_o = 1'b1;
        idx_d    = idx_inc;
      end
      ST_SRCH_CHK: begin
        mem_re_o = (idx_q < count_q);
      end
      ST_SRCH_CMP: begin
        if (mem_rdata_i == value_q) begin
          status_d = STAT_OK;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_DISP_RD: begin
        mem_re_o = 1'b1;
      end
      ST_DISP_OUT: begin
        rsp_o.status        = STAT_OK;
        rsp_o.element       = mem_rdata_i;
        rsp_o.element_valid = 1'b1;
        rsp_o.last          = (idx_inc == count_q);
        emit_o              = slot_free_i;
        if (slot_free_i) begin
          idx_d = idx_inc;
        end
      end
      ST_RESP: begin
        emit_o = slot_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import blol_pkg::*;

  // The block is built with its default list size; the predictor uses the same bound.
  localparam int unsigned Capacity = 32;

  // Random part of the stimulus, on top of the directed opening sequence.
  localparam int unsigned RandomItems = 260;

  // The settling time at the end grows with the list size, so that even a display of a
  // full list would fit in it.
  localparam int unsigned TailCycles = 4 * Capacity + 20;

  // Cycles in a row with no transaction on either channel before the run is
  // declared hung. The slowest legal stretch is a long shift or display together
  // with a long sender gap and a long receiver stall. That is well under this figure.
  localparam int unsigned WatchdogLimit = 3000;

  localparam logic [DataW-1:0] MaxValue = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinValue = 32'h8000_0000;

  // One request waiting to be driven. When drain_first is set, the driver holds
  // the request back until every response that is already owed has come.
  typedef struct {
    req_t item;
    bit   drain_first;
  } queued_req_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Requests not yet accepted, in the order they are to be sent.
  queued_req_t        req_backlog[$];
  // Responses the block owes, oldest first.
  rsp_t               awaited_rsp[$];
  // The list contents as the block should hold them.
  logic signed [31:0] list_model[$];
  // Recently inserted values, so that deletes by value often hit.
  logic [31:0]        value_pool[$];

  int unsigned send_gap;
  int unsigned hold_cnt;
  int unsigned idle_cycles;
  bit          sender_calm;
  bit          receiver_calm;
  int unsigned requests_sent;
  int unsigned responses_seen;
  int unsigned elements_shown;
  int unsigned status_tally[5];
  int unsigned error_count;

  bounded_ordered_list_engine_unit #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  always #1 clk = ~clk;

  // Reset is applied once, at the start of the run.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Applies one accepted request to the list copy and queues the responses the
  // block has to produce for it. Each request gives one response, except a display
  // of a non-empty list, which gives one response per entry from front to end.
  function automatic void predict_list_response(input req_t r);
    status_e     st;
    int unsigned n;
    int unsigned idx;
    bit          found;
    rsp_t        o;
    st = STAT_OK;
    n = list_model.size();
    idx = 0;
    o = '0;
    case (r.req_type)
      REQ_INS_FRONT, REQ_INS_POS, REQ_INS_END: begin
        if (r.req_type == REQ_INS_POS) begin
          idx = r.position;
        end else if (r.req_type == REQ_INS_END) begin
          idx = n;
        end
        // A full list is checked first, so a full list never reports a bad position.
        if (n >= Capacity) begin
          st = STAT_OVERFLOW;
        end else if (idx > n) begin
          st = STAT_RANGE;
        end else if (idx == n) begin
          list_model.push_back(r.value);
        end else begin
          list_model.insert(idx, r.value);
        end
      end
      REQ_DEL_FRONT, REQ_DEL_POS, REQ_DEL_END: begin
        if (r.req_type == REQ_DEL_POS) begin
          idx = r.position;
        end else if (r.req_type == REQ_DEL_END && n > 0) begin
          idx = n - 1;
        end
        if (n == 0) begin
          st = STAT_EMPTY;
        end else if (idx >= n) begin
          st = STAT_RANGE;
        end else begin
          list_model.delete(idx);
        end
      end
      REQ_DEL_VALUE: begin
        // Only the first entry equal to the value is removed.
        found = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
          if (!found && list_model[i] == r.value) begin
            found = 1'b1;
            idx = i;
          end
        end
        if (n == 0) begin
          st = STAT_EMPTY;
        end else if (!found) begin
          st = STAT_NOT_FOUND;
        end else begin
          list_model.delete(idx);
        end
      end
      default: begin
        if (n == 0) begin
          o.status = STAT_EMPTY;
          o.last   = 1'b1;
          awaited_rsp.push_back(o);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            o.status        = STAT_OK;
            o.element       = list_model[i];
            o.element_valid = 1'b1;
            o.length        = LenW'(n);
            o.last          = (i + 1 == n);
            awaited_rsp.push_back(o);
          end
        end
        return;
      end
    endcase
    o.status = st;
    o.length = LenW'(list_model.size());
    o.last   = 1'b1;
    awaited_rsp.push_back(o);
  endfunction

  // Idle length for either side: usually none, often a short one, now and then a
  // long one. While a side is in its calm stretch it never idles.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30 && value_pool.size() > 0) begin
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    end
    if (roll < 40) begin
      case ($urandom_range(0, 4))
        0: return MaxValue;
        1: return MinValue;
        2: return 32'hFFFF_FFFF;
        3: return 32'd1;
        default: return 32'd0;
      endcase
    end
    return $urandom();
  endfunction

  // Positions mostly run from zero to the expected list length, so that inserts
  // and deletes land inside the list, with an occasional one anywhere in the field.
  function automatic int unsigned pick_position(input int unsigned len_guess);
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 63);
    end
    return $urandom_range(0, len_guess);
  endfunction

  function automatic void add_req(input req_type_e kind, input int unsigned pos,
                                  input logic [31:0] val, input bit drain_first);
    queued_req_t q;
    q.item.req_type = kind;
    q.item.position = PosW'(pos);
    q.item.value    = val;
    q.drain_first   = drain_first;
    req_backlog.push_back(q);
    if (kind inside {REQ_INS_FRONT, REQ_INS_POS, REQ_INS_END}) begin
      value_pool.push_back(val);
      if (value_pool.size() > 24) begin
        void'(value_pool.pop_front());
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 40) begin
        $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      end
    end
  endfunction

  // Driver. A request is presented once the last one was accepted, any gap has run
  // out and, if drain_first, no response is owed. Valid then holds, with the same
  // payload, until the block takes it. Each accepted request is run through the
  // predictor at the edge that accepts it, before the block can answer it.
  always @(posedge clk or negedge rst_n) begin
    logic next_valid;
    req_t next_req;
    if (!rst_n) begin
      req_valid <= 1'b0;
      req       <= '0;
      send_gap  <= 0;
    end else begin
      next_valid = req_valid;
      next_req   = req;
      if (req_valid && req_ready) begin
        predict_list_response(req);
        void'(req_backlog.pop_front());
        requests_sent++;
        next_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          sender_calm = !sender_calm;
        end
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (req_backlog.size() > 0 &&
                     !(req_backlog[0].drain_first && awaited_rsp.size() != 0)) begin
          next_valid = 1'b1;
          next_req   = req_backlog[0].item;
          send_gap   <= pick_gap(sender_calm);
        end
      end
      req_valid <= next_valid;
      req       <= next_req;
    end
  end

  // Monitor. Every response transaction is compared field by field with the oldest
  // outstanding expectation. Ready is withheld at random so that stalls hit single
  // responses as well as the middle of long display bursts.
  always @(posedge clk or negedge rst_n) begin
    rsp_t want;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        responses_seen++;
        if (rsp.element_valid) begin
          elements_shown++;
        end
        if (int'(rsp.status) < 5) begin
          status_tally[int'(rsp.status)]++;
        end
        if (awaited_rsp.size() == 0) begin
          error_count++;
          $display("%0t: response with nothing expected, actual %p", $time, rsp);
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("element", want.element, rsp.element);
          check_field("element_valid", 32'(want.element_valid), 32'(rsp.element_valid));
          check_field("length", 32'(want.length), 32'(rsp.length));
          check_field("last", 32'(want.last), 32'(rsp.last));
        end
        if ($urandom_range(0, 59) == 0) begin
          receiver_calm = !receiver_calm;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        rsp_ready <= 1'b0;
      end else if (!receiver_calm && $urandom_range(0, 99) < 30) begin
        hold_cnt  <= pick_gap(1'b0);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog. Any transaction on either channel clears the count.
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("[bounded_ordered_list_engine_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run. The directed part walks the empty-list errors, inserts
  // at both ends and at a position equal to the length, bad positions for insert
  // and delete, duplicates, a missing value, and deleting the end of a one-element
  // list. The random part then cycles through fill, churn and drain phases so the
  // list spends time full, half full and empty. The first request of every drain
  // phase waits until every owed response has come back.
  initial begin
    int unsigned planned;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned approx_len;
    req_type_e   kind;
    logic [31:0] val;

    add_req(REQ_DISPLAY,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_FRONT, 0,  32'd0,        1'b0);
    add_req(REQ_DEL_POS,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_END,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_VALUE, 0,  32'd0,        1'b0);
    add_req(REQ_INS_FRONT, 0,  MaxValue,     1'b0);
    add_req(REQ_INS_END,   0,  MinValue,     1'b0);
    add_req(REQ_INS_POS,   2,  32'hFFFF_FFFF, 1'b0);
    add_req(REQ_INS_POS,   4,  32'd5,        1'b0);
    add_req(REQ_INS_POS,   63, 32'd6,        1'b0);
    add_req(REQ_INS_POS,   1,  32'd0,        1'b0);
    add_req(REQ_INS_FRONT, 0,  32'hFFFF_FFFF, 1'b0);
    add_req(REQ_DISPLAY,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_VALUE, 0,  32'd12345,    1'b0);
    add_req(REQ_DEL_VALUE, 0,  32'hFFFF_FFFF, 1'b0);
    add_req(REQ_DEL_POS,   63, 32'd0,        1'b0);
    add_req(REQ_DEL_POS,   4,  32'd0,        1'b0);
    add_req(REQ_DEL_POS,   1,  32'd0,        1'b0);
    add_req(REQ_DISPLAY,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_END,   0,  32'd0,        1'b0);
    add_req(REQ_DEL_FRONT, 0,  32'd0,        1'b0);
    add_req(REQ_DEL_END,   0,  32'd0,        1'b0);
    add_req(REQ_DISPLAY,   0,  32'd0,        1'b0);

    planned    = 0;
    phase      = 0;
    approx_len = 0;
    while (planned < RandomItems) begin
      phase_len = $urandom_range(35, 55);
      case (phase % 4)
        0:       ins_pct = 85;
        2:       ins_pct = 25;
        default: ins_pct = 55;
      endcase
      for (int unsigned k = 0; k < phase_len && planned < RandomItems; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          add_req(REQ_DISPLAY, $urandom_range(0, 63), $urandom(),
                  (phase % 4 == 2) && (k == 0));
        end else if (roll < ins_pct) begin
          kind = req_type_e'(3'($urandom_range(0, 2)));
          add_req(kind, pick_position(approx_len), pick_value(),
                  (phase % 4 == 2) && (k == 0));
          if (approx_len < Capacity) begin
            approx_len++;
          end
        end else begin
          kind = req_type_e'(3'($urandom_range(3, 6)));
          val  = pick_value();
          if (kind == REQ_DEL_VALUE && value_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
            val = value_pool[$urandom_range(0, value_pool.size() - 1)];
          end
          add_req(kind, pick_position(approx_len > 0 ? approx_len - 1 : 0), val,
                  (phase % 4 == 2) && (k == 0));
          if (approx_len > 0) begin
            approx_len--;
          end
        end
        planned++;
      end
      phase++;
    end

    wait (rst_n);
    while (req_backlog.size() != 0 || awaited_rsp.size() != 0) begin
      @(posedge clk);
    end
    // Let any stray response surface before the verdict.
    repeat (TailCycles) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      error_count += awaited_rsp.size();
      $display("%0t: %0d responses still outstanding", $time, awaited_rsp.size());
    end

    $display("Sent %0d list requests and checked %0d responses, %0d of them list entries.",
             requests_sent, responses_seen, elements_shown);
    $display("Statuses seen: ok %0d, empty %0d, overflow %0d, range %0d, not found %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (error_count == 0) begin
      $display("[bounded_ordered_list_engine_unit] OK");
    end else begin
      $display("[bounded_ordered_list_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/blol_pkg.sv
rtl/blol_mem.sv
rtl/blol_ctrl.sv
rtl/bounded_ordered_list_engine_unit.sv
test/testbench.sv
